// ===== hw/rtl/qtk_pkg.sv =====
// package for the quadtree tile key pipeline
// widths, fixed point constants, register indexes and the stage record
// no dependencies
package qtk_pkg;

  localparam int FRAC_BITS = 30;
  localparam int COORD_W   = 36;
  localparam int TOL_W     = 30;
  localparam int MAX_DEPTH = 28;
  localparam int DEPTH_W   = 5;
  localparam int KEY_W     = 63;
  localparam int POS_W     = 6;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t ONE_FX  = coord_t'(1) <<< FRAC_BITS;
  localparam coord_t HALF_FX = coord_t'(1) <<< (FRAC_BITS - 1);
  localparam coord_t SAT_FX  = coord_t'(8) <<< FRAC_BITS;

  localparam logic [TOL_W-1:0]   HALF_TOL  = TOL_W'(1) << (FRAC_BITS - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam logic [POS_W-1:0]   TOP_POS   = POS_W'(KEY_W - 2);

  typedef enum logic [0:0] {
    REG_TOLERANCE,
    REG_MAX_LEVEL
  } cfg_reg_t;

  typedef struct packed {
    logic                valid;
    logic                stopped;
    logic [DEPTH_W-1:0]  depth;
    logic [KEY_W-1:0]    key;
    coord_t              x0;
    coord_t              y0;
    coord_t              x1;
    coord_t              y1;
  } stage_t;

endpackage

// ===== hw/rtl/quadtree_key_from_box.sv =====
// top level of the quadtree tile key pipeline: config registers, level chain, result register
// uses qtk_pkg and qtk_level
//
// A box enters on any cycle that start is high; busy is always low, so one box a cycle
// is taken. The box runs through one registered stage per quadtree level (MAX_DEPTH
// stages) behind an input register, and its key appears with a one-cycle done strobe
// from the result register behind the last stage, in input order. Results cannot
// be held off: done must be sampled when it shows. Configuration writes are always
// ready and must be made only with no box in flight.
module quadtree_key_from_box (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [qtk_pkg::COORD_W-1:0] min_x,
  input  logic [qtk_pkg::COORD_W-1:0] min_y,
  input  logic [qtk_pkg::COORD_W-1:0] max_x,
  input  logic [qtk_pkg::COORD_W-1:0] max_y,
  output logic                        done,
  output logic [qtk_pkg::KEY_W-1:0]   tile_key,
  output logic [qtk_pkg::DEPTH_W-1:0] depth_reached,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  qtk_pkg::cfg_reg_t           cfg_index,
  input  logic [qtk_pkg::TOL_W-1:0]   cfg_data
);
  import qtk_pkg::*;

  logic [TOL_W-1:0]   tolerance;
  logic [DEPTH_W-1:0] limit;
  logic [DEPTH_W-1:0] level_data;
  stage_t             stage [0:MAX_DEPTH];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign level_data = cfg_data[DEPTH_W-1:0];

  // clamped values are stored
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_W'(53687091);
      limit <= DEPTH_W'(18);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TOLERANCE: tolerance <= (cfg_data > HALF_TOL) ? HALF_TOL : cfg_data;
        REG_MAX_LEVEL: limit <= (level_data > DEPTH_MAX) ? DEPTH_MAX : level_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage[0].valid <= 1'b0;
    end else begin
      stage[0].valid <= start && !busy;
    end
    stage[0].stopped <= 1'b0;
    stage[0].depth   <= '0;
    stage[0].key     <= '0;
    stage[0].x0      <= min_x;
    stage[0].y0      <= min_y;
    stage[0].x1      <= max_x;
    stage[0].y1      <= max_y;
  end

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_level
    qtk_level u_level (
      .clk        (clk),
      .rst        (rst),
      .level_index(DEPTH_W'(i)),
      .tolerance  (tolerance),
      .limit      (limit),
      .stage_in   (stage[i]),
      .stage_out  (stage[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage[MAX_DEPTH].valid;
    end
    tile_key <= stage[MAX_DEPTH].key | KEY_W'(stage[MAX_DEPTH].depth);
    depth_reached <= stage[MAX_DEPTH].depth;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(MAX_DEPTH + 2) done)
    else $error("accepted box produced no result at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, MAX_DEPTH + 2))
    else $error("result without a matching start transfer");

  a_depth_field: assert property (@(posedge clk) disable iff (rst)
    done |-> tile_key[DEPTH_W-1:0] == depth_reached)
    else $error("key level field differs from depth");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> depth_reached <= DEPTH_MAX)
    else $error("depth beyond the deepest level");

endmodule

// ===== hw/rtl/qtk_level.sv =====
// one quadtree level: saturate, pick a quadrant, recentre and double the box
// registered stage record out; uses qtk_pkg
module qtk_level (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [qtk_pkg::DEPTH_W-1:0] level_index,
  input  logic [qtk_pkg::TOL_W-1:0]   tolerance,
  input  logic [qtk_pkg::DEPTH_W-1:0] limit,
  input  qtk_pkg::stage_t             stage_in,
  output qtk_pkg::stage_t             stage_out
);
  import qtk_pkg::*;

  function automatic coord_t sat(input coord_t v);
    coord_t r;
    if (v > SAT_FX) r = SAT_FX;
    else if (v < -SAT_FX) r = -SAT_FX;
    else r = v;
    return r;
  endfunction

  function automatic coord_t absv(input coord_t v);
    coord_t r;
    r = (v < 0) ? -v : v;
    return r;
  endfunction

  coord_t x0, y0, x1, y1;
  coord_t ax0, ay0, ax1, ay1;
  coord_t bs, ob, neg_ob;
  logic outside, west, east, north, south, hit, advance;
  logic [1:0] q;
  coord_t xh0, xh1, yh0, yh1;
  logic [POS_W-1:0] pos;
  stage_t stage_next;

  always_comb begin
    x0 = sat(stage_in.x0);
    y0 = sat(stage_in.y0);
    x1 = sat(stage_in.x1);
    y1 = sat(stage_in.y1);
    ax0 = absv(x0);
    ay0 = absv(y0);
    ax1 = absv(x1);
    ay1 = absv(y1);
    bs = coord_t'(tolerance);
    ob = ONE_FX + bs;
    neg_ob = -ob;

    outside = (x0 < neg_ob) || (y0 < neg_ob) || (x1 > ob) || (y1 > ob);
    west  = (x1 < bs) && (ax1 < ax0);
    east  = (x0 > -bs) && (ax1 >= ax0);
    north = (y0 > -bs) && (ay1 >= ay0);
    south = (y1 < bs) && (ay1 < ay0);

    hit = 1'b1;
    q = 2'd0;
    if (outside) hit = 1'b0;
    else if (x1 <= 0 && y0 >= 0) q = 2'd0;
    else if (x0 >= 0 && y0 >= 0) q = 2'd1;
    else if (x1 <= 0 && y1 <= 0) q = 2'd2;
    else if (x0 >= 0 && y1 <= 0) q = 2'd3;
    else if (west && north) q = 2'd0;
    else if (east && north) q = 2'd1;
    else if (west && south) q = 2'd2;
    else if (east && south) q = 2'd3;
    else hit = 1'b0;

    advance = stage_in.valid && !stage_in.stopped && (level_index < limit) && hit;

    // q[0] marks east, q[1] marks south
    xh0 = q[0] ? (x0 - HALF_FX) : (x0 + HALF_FX);
    xh1 = q[0] ? (x1 - HALF_FX) : (x1 + HALF_FX);
    yh0 = q[1] ? (y0 + HALF_FX) : (y0 - HALF_FX);
    yh1 = q[1] ? (y1 + HALF_FX) : (y1 - HALF_FX);
    pos = TOP_POS - {level_index, 1'b0};

    stage_next = stage_in;
    if (advance) begin
      stage_next.x0 = xh0 <<< 1;
      stage_next.x1 = xh1 <<< 1;
      stage_next.y0 = yh0 <<< 1;
      stage_next.y1 = yh1 <<< 1;
      stage_next.key = stage_in.key | (KEY_W'(q) << pos);
      stage_next.depth = level_index + DEPTH_W'(1);
    end else begin
      stage_next.stopped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.stopped <= stage_next.stopped;
    stage_out.depth   <= stage_next.depth;
    stage_out.key     <= stage_next.key;
    stage_out.x0      <= stage_next.x0;
    stage_out.y0      <= stage_next.y0;
    stage_out.x1      <= stage_next.x1;
    stage_out.y1      <= stage_next.y1;
  end

endmodule
